[src/alfp_pkg.sv]
// ----------------------------------------------------------------------------
// alfp_pkg
// Shared constants, types and control bundles for the additive feedback
// random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package alfp_pkg;

    // ring geometry
    localparam int DEGREE         = 31;
    localparam int SEPARATION     = 3;
    localparam int DISCARD_FACTOR = 10;
    localparam int DISCARD_LEN    = DEGREE * DISCARD_FACTOR;

    // widths
    localparam int WORD_W     = 32;
    localparam int RES_W      = 31;
    localparam int MUL_W      = 15;
    localparam int PROD_W     = RES_W + MUL_W;
    localparam int FILL_CNT_W = $clog2(DEGREE);
    localparam int DISC_CNT_W = $clog2(DISCARD_LEN);

    // minimal-standard constants
    localparam logic [MUL_W-1:0] MINSTD_MUL = 15'd16807;
    localparam logic [RES_W:0]   MINSTD_M   = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_DISCARD
    } alfp_state_t;

    // control from the sequencer to the seed-step unit
    typedef struct packed {
        logic load;    // capture a new seed
        logic mul_en;  // register seed-state times multiplier
        logic red_en;  // fold product and update state
    } alfp_seed_ctrl_t;

endpackage : alfp_pkg

`default_nettype wire

[src/additive_lagged_fibonacci_prng_top.sv]
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_prng_top
// Additive feedback random generator (31-word ring, lag 3), random() type 3.
// ----------------------------------------------------------------------------
// A request with func = 1 returns the next 31-bit random number; the block
// takes one such request per cycle as long as the result register drains.
// A request with func = 0 reseeds: word 0 takes the seed, words 1..30 come
// from the 16807 minimal-standard step (ST_MUL then ST_RED per word in the
// seed-fill unit), then 310 outputs are run and dropped. A reseed keeps the
// block busy through the fill and the discard and produces no result.
// Seed 0 gives an all-zero ring and all-zero outputs. After reset the ring
// is zero, so next requests return 0 until the first reseed.
// The ring is a chain of word cells that rotates by one per generated number:
// cell 0 always holds the rear word and cell SEPARATION the front word, so no
// index registers exist; the updated front word re-enters at cell
// SEPARATION-1 and the old rear word wraps to the last cell.
// ----------------------------------------------------------------------------
`default_nettype none

module additive_lagged_fibonacci_prng_top
    import alfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [WORD_W-1:0] seed_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [RES_W-1:0]  random_value
);

    alfp_state_t state_reg;
    alfp_state_t state_next;

    logic [FILL_CNT_W-1:0] fill_cnt_reg;
    logic [FILL_CNT_W-1:0] fill_cnt_next;
    logic [DISC_CNT_W-1:0] disc_cnt_reg;
    logic [DISC_CNT_W-1:0] disc_cnt_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [RES_W-1:0] random_value_reg;
    logic [RES_W-1:0] random_value_next;

    logic              accept;
    logic              chain_shift;
    logic              step_mode;     // 1: generate, 0: push fill word
    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] feedback_sum;
    logic [RES_W-1:0]  seed_word;
    alfp_seed_ctrl_t   seed_ctrl;

    logic [WORD_W-1:0] tap_word [DEGREE];
    logic [WORD_W-1:0] tap_in   [DEGREE];

    // ------------------------------------------------------------------
    // ring chain
    // ------------------------------------------------------------------
    assign feedback_sum = tap_word[0] + tap_word[SEPARATION];

    genvar k;
    generate
        for (k = 0; k < DEGREE; k++)
        begin : g_ring
            if (k == DEGREE - 1)
            begin : g_tail
                assign tap_in[k] = step_mode ? tap_word[0] : fill_word;
            end
            else if (k == SEPARATION - 1)
            begin : g_front
                assign tap_in[k] = step_mode ? feedback_sum : tap_word[k+1];
            end
            else
            begin : g_plain
                assign tap_in[k] = tap_word[k+1];
            end

            alfp_cell u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (chain_shift),
                .word_in (tap_in[k]),
                .word    (tap_word[k])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // seed-fill unit
    // ------------------------------------------------------------------
    alfp_minstd u_minstd (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (seed_ctrl),
        .seed     (seed_value),
        .word_new (seed_word)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !func)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                if (fill_cnt_reg == FILL_CNT_W'(DEGREE - 2))
                begin
                    state_next = ST_DISCARD;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_DISCARD:
            begin
                if (disc_cnt_reg == DISC_CNT_W'(DISCARD_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        chain_shift      = 1'b0;
        step_mode        = 1'b0;
        fill_word        = {1'b0, seed_word};
        seed_ctrl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = !out_valid_reg || out_ready;
                chain_shift    = in_valid && in_ready;
                step_mode      = func;
                fill_word      = seed_value;
                seed_ctrl.load = in_valid && in_ready && !func;
            end
            ST_MUL:
            begin
                seed_ctrl.mul_en = 1'b1;
            end
            ST_RED:
            begin
                seed_ctrl.red_en = 1'b1;
                chain_shift      = 1'b1;
            end
            ST_DISCARD:
            begin
                chain_shift = 1'b1;
                step_mode   = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // counters and result register
    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        disc_cnt_next = disc_cnt_reg;
        if (seed_ctrl.load)
        begin
            fill_cnt_next = '0;
            disc_cnt_next = '0;
        end
        else if (state_reg == ST_RED)
        begin
            fill_cnt_next = fill_cnt_reg + FILL_CNT_W'(1);
        end
        else if (state_reg == ST_DISCARD)
        begin
            disc_cnt_next = disc_cnt_reg + DISC_CNT_W'(1);
        end

        out_valid_next    = out_valid_reg && !out_ready;
        random_value_next = random_value_reg;
        if (accept && func)
        begin
            out_valid_next    = 1'b1;
            random_value_next = feedback_sum[WORD_W-1:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_cnt_reg  <= '0;
            disc_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            disc_cnt_reg  <= disc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        random_value_reg <= random_value_next;
    end

    assign out_valid    = out_valid_reg;
    assign random_value = random_value_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready raised while sequencer busy");

    a_reseed_starts_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !func) |=> (state_reg == ST_MUL && fill_cnt_reg == '0))
        else $error("reseed did not start the fill");

    a_next_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func) |=> out_valid)
        else $error("next request produced no result");

    a_discard_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISCARD && disc_cnt_reg == DISC_CNT_W'(DISCARD_LEN - 1))
        |=> (state_reg == ST_IDLE))
        else $error("discard run did not end on count");

    a_fill_leads_discard: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RED && fill_cnt_reg == FILL_CNT_W'(DEGREE - 2))
        |=> (state_reg == ST_DISCARD && disc_cnt_reg == '0))
        else $error("fill did not hand over to discard");

endmodule : additive_lagged_fibonacci_prng_top

`default_nettype wire

[src/alfp_cell.sv]
// ----------------------------------------------------------------------------
// alfp_cell
// One word of the ring; loads its neighbor's word when the chain moves.
// ----------------------------------------------------------------------------
`default_nettype none

module alfp_cell
    import alfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire logic [WORD_W-1:0] word_in,
    output logic      [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = shift ? word_in : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule : alfp_cell

`default_nettype wire

[src/alfp_minstd.sv]
// ----------------------------------------------------------------------------
// alfp_minstd
// Seed-fill unit: w <- 16807 * w mod (2^31 - 1), a multiply step then a fold step per word.
// ----------------------------------------------------------------------------
`default_nettype none

module alfp_minstd
    import alfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire alfp_seed_ctrl_t   ctrl,
    input  wire logic [WORD_W-1:0] seed,
    output logic      [RES_W-1:0]  word_new
);

    logic [RES_W-1:0]  w_reg;
    logic [RES_W-1:0]  w_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    logic [RES_W:0]    seed_sum;
    logic [RES_W-1:0]  seed_mod;
    logic [RES_W-1:0]  seed_res;
    logic [RES_W:0]    fold_sum;

    // signed seed to residue mod M; 2^32 == 2 mod M, so negatives lose 2
    always_comb
    begin
        seed_sum = {1'b0, seed[RES_W-1:0]} + (RES_W+1)'(seed[WORD_W-1]);
        if (seed_sum >= MINSTD_M)
        begin
            seed_mod = RES_W'(seed_sum - MINSTD_M);
        end
        else
        begin
            seed_mod = seed_sum[RES_W-1:0];
        end
        if (!seed[WORD_W-1])
        begin
            seed_res = seed_mod;
        end
        else if (seed_mod >= RES_W'(2))
        begin
            seed_res = seed_mod - RES_W'(2);
        end
        else
        begin
            seed_res = RES_W'({1'b0, seed_mod} + MINSTD_M - (RES_W+1)'(2));
        end
    end

    // Mersenne fold of the registered product
    always_comb
    begin
        fold_sum = {1'b0, prod_reg[RES_W-1:0]} + (RES_W+1)'(prod_reg[PROD_W-1:RES_W]);
        if (fold_sum >= MINSTD_M)
        begin
            word_new = RES_W'(fold_sum - MINSTD_M);
        end
        else
        begin
            word_new = fold_sum[RES_W-1:0];
        end
    end

    always_comb
    begin
        prod_next = PROD_W'(w_reg) * PROD_W'(MINSTD_MUL);
        w_next    = w_reg;
        if (ctrl.load)
        begin
            w_next = seed_res;
        end
        else if (ctrl.red_en)
        begin
            w_next = word_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else
        begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule : alfp_minstd

`default_nettype wire
